FILE: hw/rtl/tosu_pkg.sv
package tosu_pkg;

	localparam int unsigned CMD_W     = 4;
	localparam int unsigned TAG_W     = 3;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned IN_VAL_W  = 32;
	localparam int unsigned OUT_VAL_W = 32;
	localparam int unsigned S_TDATA_W = 40;

	localparam logic [TAG_W-1:0] TAG_INT = '0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 4'd0,
		CMD_POP    = 4'd1,
		CMD_DUP    = 4'd2,
		CMD_SWAP   = 4'd3,
		CMD_OVER   = 4'd4,
		CMD_PICK   = 4'd5,
		CMD_PUT    = 4'd6,
		CMD_ROT    = 4'd7,
		CMD_ROTATE = 4'd8,
		CMD_DEPTH  = 4'd9,
		CMD_ROLL   = 4'd10
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_NOT_INT   = 3'd3,
		ST_NOT_POS   = 3'd4,
		ST_NEG_COUNT = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FETCH1,
		OP_FETCH2,
		OP_FETCH3,
		OP_EXEC,
		OP_PICK_RD,
		OP_PICK_WR,
		OP_DIV_WAIT,
		OP_RSET,
		OP_RA,
		OP_RB,
		OP_RC,
		OP_RD,
		OP_TOP,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic err;
		logic go_pick;
		logic go_div;
		logic go_rot;
		logic div_done;
		logic lo_lt_hi;
		logic last_phase;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/tosu_mod.sv
module tosu_mod #(
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned CW         = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] mag,
	input  logic                  neg,
	input  logic [CW-1:0]         divisor,
	output logic                  done,
	output logic [CW-1:0]         result
);
	localparam int unsigned IW = $clog2(VALUE_BITS + 1);

	logic [CW-1:0]         rem_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [IW-1:0]         it_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic [CW:0]           trial;
	logic [CW:0]           dvs;

	assign trial = {rem_q, sh_q[VALUE_BITS-1]};
	assign dvs   = {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= IW'(VALUE_BITS);
			end else if (busy_q) begin
				it_q <= it_q - IW'(1);
				if (it_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= mag;
			neg_q <= neg;
		end else if (busy_q) begin
			if (trial >= dvs) begin
				rem_q <= CW'(trial - dvs);
			end else begin
				rem_q <= trial[CW-1:0];
			end
			sh_q <= {sh_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// A negative dividend leaves a remainder that is folded back into 0..n-1.
	assign done   = done_q;
	assign result = (neg_q && rem_q != '0) ? divisor - rem_q : rem_q;

endmodule

FILE: hw/rtl/tosu_dp.sv
module tosu_dp #(
	parameter int unsigned DEPTH      = 256,
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned CW         = 9,
	parameter int unsigned M_TDATA_W  = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tosu_pkg::ctrl_cmd_t           ctrl,
	output tosu_pkg::dp_sts_t             sts,
	input  logic [tosu_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [tosu_pkg::TAG_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [M_TDATA_W-1:0]          m_tdata,
	output logic [tosu_pkg::TAG_W-1:0]    m_tuser
);
	import tosu_pkg::*;

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned EW   = VALUE_BITS + TAG_W;
	localparam int unsigned CMPW = ((VALUE_BITS > CW) ? VALUE_BITS : CW) + 1;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q, t1_q, t2_q, a_q;
	logic [AW-1:0] raddr, waddr, pick_q;
	logic [EW-1:0] wdata;
	logic          we;

	cmd_t                  cmd_q;
	logic [VALUE_BITS-1:0] pv_q;
	logic [TAG_W-1:0]      ptag_q;
	logic [CW-1:0]         cnt_q, top_q, n_q, m_q, lo_q, hi_q;
	logic [1:0]            phase_q;
	status_t               status_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic [TAG_W-1:0]      m_tuser_q;

	logic [CW-1:0]                cm1, cm2, cm3, rest_c, n_cw, pick_src, put_dst;
	logic signed [VALUE_BITS-1:0] v1, v2, nsel;
	logic [TAG_W-1:0]             g1, g2;
	logic signed [CMPW-1:0]       n_x, n_abs, rest_x;
	logic                         full, err, div_start, out_free;
	status_t                      err_st;
	logic [VALUE_BITS-1:0]        m_mag;
	logic                         div_done;
	logic [CW-1:0]                div_res;
	logic signed [63:0]           top_wide;

	assign cm1  = cnt_q - CW'(1);
	assign cm2  = cnt_q - CW'(2);
	assign cm3  = cnt_q - CW'(3);
	assign full = (cnt_q == CW'(DEPTH));
	assign v1   = signed'(t1_q[VALUE_BITS-1:0]);
	assign v2   = signed'(t2_q[VALUE_BITS-1:0]);
	assign g1   = t1_q[EW-1:VALUE_BITS];
	assign g2   = t2_q[EW-1:VALUE_BITS];
	assign nsel = (cmd_q == CMD_ROLL) ? v2 : v1;
	assign n_x  = CMPW'(nsel);
	assign n_abs = (n_x < 0) ? -n_x : n_x;
	assign n_cw = n_abs[CW-1:0];
	assign rest_c = (cmd_q == CMD_PUT || cmd_q == CMD_ROLL) ? cm2 : cm1;
	assign rest_x = signed'(CMPW'(rest_c));
	assign pick_src = cm1 - n_cw;
	assign put_dst  = cm2 - n_cw;
	assign m_mag = (v1 < 0) ? VALUE_BITS'(-v1) : VALUE_BITS'(v1);

	always_comb begin
		err_st = ST_OK;
		unique case (cmd_q)
			CMD_PUSH, CMD_DEPTH: begin
				if (full) err_st = ST_OVERFLOW;
			end
			CMD_POP: begin
				if (cnt_q == '0) err_st = ST_UNDERFLOW;
			end
			CMD_DUP: begin
				priority if (cnt_q == '0) err_st = ST_UNDERFLOW;
				else if (full) err_st = ST_OVERFLOW;
				else err_st = ST_OK;
			end
			CMD_SWAP: begin
				if (cnt_q < CW'(2)) err_st = ST_UNDERFLOW;
			end
			CMD_OVER: begin
				priority if (cnt_q < CW'(2)) err_st = ST_UNDERFLOW;
				else if (full) err_st = ST_OVERFLOW;
				else err_st = ST_OK;
			end
			CMD_ROT: begin
				if (cnt_q < CW'(3)) err_st = ST_UNDERFLOW;
			end
			CMD_PICK, CMD_PUT: begin
				priority if ((cmd_q == CMD_PICK) ? (cnt_q == '0) : (cnt_q < CW'(2)))
					err_st = ST_UNDERFLOW;
				else if (g1 != TAG_INT) err_st = ST_NOT_INT;
				else if (n_x <= 0) err_st = ST_NOT_POS;
				else if (n_x > rest_x) err_st = ST_UNDERFLOW;
				else err_st = ST_OK;
			end
			CMD_ROTATE: begin
				priority if (cnt_q == '0) err_st = ST_UNDERFLOW;
				else if (g1 != TAG_INT) err_st = ST_NOT_INT;
				else if (n_abs > rest_x) err_st = ST_UNDERFLOW;
				else err_st = ST_OK;
			end
			CMD_ROLL: begin
				priority if (cnt_q < CW'(2)) err_st = ST_UNDERFLOW;
				else if (g1 != TAG_INT || g2 != TAG_INT) err_st = ST_NOT_INT;
				else if (n_x < 0) err_st = ST_NEG_COUNT;
				else if (n_x > rest_x) err_st = ST_UNDERFLOW;
				else err_st = ST_OK;
			end
			default: err_st = ST_OK;
		endcase
	end

	assign err       = (err_st != ST_OK);
	assign div_start = (ctrl.op == OP_EXEC) && !err && (cmd_q == CMD_ROLL) && (n_x != 0);
	assign out_free  = !m_tvalid_q || m_tready;

	tosu_mod #(.VALUE_BITS(VALUE_BITS), .CW(CW)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.mag     (m_mag),
		.neg     (v1 < 0),
		.divisor (n_cw),
		.done    (div_done),
		.result  (div_res)
	);

	// A rotate by zero moves nothing, so it skips the reversal passes.
	always_comb begin
		sts.err        = err;
		sts.go_pick    = (cmd_q == CMD_PICK);
		sts.go_div     = (cmd_q == CMD_ROLL) && (n_x != 0);
		sts.go_rot     = (cmd_q == CMD_SWAP || cmd_q == CMD_ROT ||
			(cmd_q == CMD_ROTATE && n_x != 0));
		sts.div_done   = div_done;
		sts.lo_lt_hi   = (lo_q < hi_q);
		sts.last_phase = (phase_q == 2'd2);
		sts.out_free   = out_free;
	end

	always_comb begin
		unique case (ctrl.op)
			OP_FETCH2:  raddr = cm2[AW-1:0];
			OP_PICK_RD: raddr = pick_q;
			OP_RA:      raddr = lo_q[AW-1:0];
			OP_RB:      raddr = hi_q[AW-1:0];
			default:    raddr = cm1[AW-1:0];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = t1_q;
		unique case (ctrl.op)
			OP_EXEC: begin
				if (!err) begin
					unique case (cmd_q)
						CMD_PUSH: begin
							we    = 1'b1;
							wdata = {ptag_q, pv_q};
						end
						CMD_DUP: we = 1'b1;
						CMD_OVER: begin
							we    = 1'b1;
							wdata = t2_q;
						end
						CMD_DEPTH: begin
							we    = 1'b1;
							wdata = {TAG_INT, VALUE_BITS'(cnt_q)};
						end
						CMD_PUT: begin
							we    = 1'b1;
							waddr = put_dst[AW-1:0];
							wdata = t2_q;
						end
						default: we = 1'b0;
					endcase
				end
			end
			OP_PICK_WR: begin
				we    = 1'b1;
				waddr = cm1[AW-1:0];
				wdata = rd_q;
			end
			OP_RC: begin
				we    = 1'b1;
				waddr = lo_q[AW-1:0];
				wdata = rd_q;
			end
			OP_RD: begin
				we    = 1'b1;
				waddr = hi_q[AW-1:0];
				wdata = a_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			phase_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_EXEC && !err) begin
				unique case (cmd_q)
					CMD_PUSH, CMD_DUP, CMD_OVER, CMD_DEPTH: cnt_q <= cnt_q + CW'(1);
					CMD_POP, CMD_ROTATE:                    cnt_q <= cm1;
					CMD_PUT, CMD_ROLL:                      cnt_q <= cm2;
					default:                                cnt_q <= cnt_q;
				endcase
				phase_q <= '0;
			end else if (ctrl.op == OP_RA && !(lo_q < hi_q)) begin
				phase_q <= phase_q + 2'd1;
			end
			if (ctrl.op == OP_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign top_wide = 64'(signed'(rd_q[VALUE_BITS-1:0]));

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				cmd_q  <= cmd_t'(s_tdata[CMD_W-1:0]);
				pv_q   <= VALUE_BITS'(64'(signed'(s_tdata[CMD_W+IN_VAL_W-1:CMD_W])));
				ptag_q <= s_tuser;
			end
			OP_FETCH2: t1_q <= rd_q;
			OP_FETCH3: t2_q <= rd_q;
			OP_EXEC: begin
				status_q <= err_st;
				pick_q   <= pick_src[AW-1:0];
				unique case (cmd_q)
					CMD_SWAP: begin
						top_q <= cm1;
						n_q   <= CW'(2);
						m_q   <= CW'(1);
					end
					CMD_ROT: begin
						top_q <= cm1;
						n_q   <= CW'(3);
						m_q   <= CW'(2);
					end
					CMD_ROTATE: begin
						top_q <= cm2;
						n_q   <= n_cw;
						priority if (n_x > 0) m_q <= n_cw - CW'(1);
						else if (n_x < 0) m_q <= CW'(1);
						else m_q <= '0;
					end
					default: begin
						top_q <= cm3;
						n_q   <= n_cw;
						m_q   <= '0;
					end
				endcase
			end
			OP_RSET: begin
				unique case (phase_q)
					2'd0: begin
						lo_q <= top_q - m_q + CW'(1);
						hi_q <= top_q;
					end
					2'd1: begin
						lo_q <= top_q - n_q + CW'(1);
						hi_q <= top_q - m_q;
					end
					default: begin
						lo_q <= top_q - n_q + CW'(1);
						hi_q <= top_q;
					end
				endcase
			end
			OP_RB: a_q <= rd_q;
			OP_RD: begin
				lo_q <= lo_q + CW'(1);
				hi_q <= hi_q - CW'(1);
			end
			OP_OUT: begin
				if (out_free) begin
					if (cnt_q == '0) begin
						m_tdata_q <= M_TDATA_W'({OUT_VAL_W'(0), cnt_q, status_q});
						m_tuser_q <= '0;
					end else begin
						m_tdata_q <= M_TDATA_W'({top_wide[OUT_VAL_W-1:0], cnt_q, status_q});
						m_tuser_q <= rd_q[EW-1:VALUE_BITS];
					end
				end
			end
			default: begin
			end
		endcase
		if (div_done) begin
			m_q <= div_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stack count beyond depth");

	a_err_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_EXEC && err) |=> $stable(cnt_q))
		else $error("failed command changed the count");

	a_rot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_RA && lo_q < hi_q) |-> (hi_q < cnt_q))
		else $error("rotation beyond the live entries");

	a_out_from_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_tvalid_q)) |-> ($past(ctrl.op) == OP_OUT))
		else $error("result raised outside the output step");
`endif

endmodule

FILE: hw/rtl/tosu_ctrl.sv
module tosu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tosu_pkg::dp_sts_t   sts,
	output tosu_pkg::ctrl_cmd_t ctrl
);
	import tosu_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_F1     = 15'b000000000000010,
		S_F2     = 15'b000000000000100,
		S_F3     = 15'b000000000001000,
		S_EXEC   = 15'b000000000010000,
		S_PA     = 15'b000000000100000,
		S_PB     = 15'b000000001000000,
		S_DIV    = 15'b000000010000000,
		S_RSET   = 15'b000000100000000,
		S_RA     = 15'b000001000000000,
		S_RB     = 15'b000010000000000,
		S_RC     = 15'b000100000000000,
		S_RD     = 15'b001000000000000,
		S_TOP    = 15'b010000000000000,
		S_OUT    = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctrl.op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctrl.op = OP_LOAD;
					state_d = S_F1;
				end
			end
			S_F1: begin
				ctrl.op = OP_FETCH1;
				state_d = S_F2;
			end
			S_F2: begin
				ctrl.op = OP_FETCH2;
				state_d = S_F3;
			end
			S_F3: begin
				ctrl.op = OP_FETCH3;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				ctrl.op = OP_EXEC;
				priority if (sts.err) state_d = S_TOP;
				else if (sts.go_pick) state_d = S_PA;
				else if (sts.go_div) state_d = S_DIV;
				else if (sts.go_rot) state_d = S_RSET;
				else state_d = S_TOP;
			end
			S_PA: begin
				ctrl.op = OP_PICK_RD;
				state_d = S_PB;
			end
			S_PB: begin
				ctrl.op = OP_PICK_WR;
				state_d = S_TOP;
			end
			S_DIV: begin
				ctrl.op = OP_DIV_WAIT;
				if (sts.div_done) state_d = S_RSET;
			end
			S_RSET: begin
				ctrl.op = OP_RSET;
				state_d = S_RA;
			end
			S_RA: begin
				ctrl.op = OP_RA;
				priority if (sts.lo_lt_hi) state_d = S_RB;
				else if (sts.last_phase) state_d = S_TOP;
				else state_d = S_RSET;
			end
			S_RB: begin
				ctrl.op = OP_RB;
				state_d = S_RC;
			end
			S_RC: begin
				ctrl.op = OP_RC;
				state_d = S_RD;
			end
			S_RD: begin
				ctrl.op = OP_RD;
				state_d = S_RA;
			end
			S_TOP: begin
				ctrl.op = OP_TOP;
				state_d = S_OUT;
			end
			S_OUT: begin
				ctrl.op = OP_OUT;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

FILE: hw/rtl/typed_operand_stack_unit.sv
// Operand stack of tagged words with Forth-style stack commands.
// Input channel s_*: one transfer carries one command, with the word and tag
// that a push places on the stack. Output channel m_*: every command yields
// exactly one result transfer with its status, the new entry count and the
// word and tag now on top (zero when the stack is empty).
// A command fetches the two top entries, checks them, executes and reads the
// new top back; pick also reads the picked entry and writes it over the top.
// Swap, rot, rotate and roll reverse ranges of the stack memory, reading
// and writing back each pair of entries exchanged in the states RA, RB, RC
// and RD; roll first reduces its count with a bit-serial remainder unit.
// One command is worked on at a time.
// The result sits in an output register, so the next command is taken while
// the previous result is still waiting; a stalled receiver holds the unit
// only at the point where the following result is ready to go out.
// Reset empties the stack; the memory itself is not cleared.
module typed_operand_stack_unit #(
	parameter int unsigned DEPTH      = 256,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// command [3:0], push_value [35:4], zero fill above
	input  logic [tosu_pkg::S_TDATA_W-1:0] s_tdata,
	// push_tag [2:0]
	input  logic [tosu_pkg::TAG_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// status [2:0], stack_count [CW+2:3], top_value above it, zero fill above
	output logic [((tosu_pkg::STATUS_W + $clog2(DEPTH + 1) + tosu_pkg::OUT_VAL_W + 7) / 8) * 8 - 1:0]
		m_tdata,
	// top_tag [2:0]
	output logic [tosu_pkg::TAG_W-1:0] m_tuser
);
	import tosu_pkg::*;

	localparam int unsigned CW        = $clog2(DEPTH + 1);
	localparam int unsigned M_TDATA_W = ((STATUS_W + CW + OUT_VAL_W + 7) / 8) * 8;

	ctrl_cmd_t ctrl;
	dp_sts_t   sts;

	tosu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	tosu_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.CW         (CW),
		.M_TDATA_W  (M_TDATA_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
